@@ src/triangle_facet_normal_macros.svh @@
// Assertion macros for the triangle facet normal block.
`ifndef TRIANGLE_FACET_NORMAL_MACROS_SVH
`define TRIANGLE_FACET_NORMAL_MACROS_SVH

`ifndef SYNTHESIS
`define TFN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfn check failed");
`define TFN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfn check failed");
`else
`define TFN_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TFN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

@@ src/tfn_pkg.sv @@
// Types, constants and step functions of the triangle facet normal block.
package tfn_pkg;

   localparam int OUT_W      = 32;
   localparam int NORM_BITS  = 31;
   localparam int ONE_SHIFT  = 30;
   localparam int ROOT_W     = 32;
   localparam int RAD_W      = 64;
   localparam int Q_W        = 31;
   localparam int SQ_STAGES  = 4;
   localparam int RT_STEPS   = 8;
   localparam int DV_STAGES  = 4;
   localparam int DV_STEPS   = 8;
   localparam logic [31:0] MIN_LEN_RESET = 32'd4096;

   typedef struct packed {
      logic [RAD_W-1:0]  x;
      logic [ROOT_W-1:0] q;
      logic [35:0]       r;
   } root_type;

   typedef struct packed {
      logic [Q_W-1:0]    n;
      logic [ROOT_W-1:0] r;
      logic [Q_W-1:0]    q;
   } div_type;

   // one bit pair of the digit-by-digit square root
   function automatic root_type root_step(root_type s);
      root_type   n;
      logic [35:0] rr;
      logic [35:0] t;
      rr  = {s.r[33:0], s.x[RAD_W-1 -: 2]};
      t   = {2'b00, s.q, 2'b01};
      n.x = {s.x[RAD_W-3:0], 2'b00};
      if (rr >= t) begin
         n.r = rr - t;
         n.q = {s.q[ROOT_W-2:0], 1'b1};
      end else begin
         n.r = rr;
         n.q = {s.q[ROOT_W-2:0], 1'b0};
      end
      return n;
   endfunction

   // one quotient bit of restoring division
   function automatic div_type div_step(div_type s, logic [ROOT_W-1:0] d);
      div_type        n;
      logic [ROOT_W:0] rr;
      rr  = {s.r, s.n[Q_W-1]};
      n.n = {s.n[Q_W-2:0], 1'b0};
      if (rr >= {1'b0, d}) begin
         n.r = ROOT_W'(rr - {1'b0, d});
         n.q = {s.q[Q_W-2:0], 1'b1};
      end else begin
         n.r = rr[ROOT_W-1:0];
         n.q = {s.q[Q_W-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

@@ src/triangle_facet_normal.sv @@
// Triangle facet normal: edge cross product, length test and unit normal, fully pipelined.
//
// One triangle (three vertices, signed fixed point, COORD_WIDTH bits each)
// enters per cycle and one result leaves per cycle while the output is not
// stalled, through 18 pipeline stages plus the output register. The stages
// are: edge subtract, six products, cross difference, magnitude, squares
// and leading-one chunks, threshold test and shift amount, normalization to
// 31 bits, squares, sum, four square-root stages of 8 bits each, divide
// setup, and four divide stages of 8 quotient bits each, 7 in the last
// (three lanes in parallel). Each stage holds while the stage after it is
// full and stalled, so empty slots close up and input is taken while a
// result waits. The result is a Q2.30 unit normal, or zero with rsp_degenerate
// set when the exact cross product length is at or below csr min_length. A
// csr write reaches the threshold test through min_len_ff and then min_sq_ff.
module triangle_facet_normal #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [31:0]                   csr_wr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_c_y,
   input  logic signed [COORD_WIDTH-1:0] req_c_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_normal_x,
   output logic signed [31:0]            rsp_normal_y,
   output logic signed [31:0]            rsp_normal_z,
   output logic                          rsp_degenerate
);

`include "triangle_facet_normal_macros.svh"

   // widths: edge, product, cross, magnitude
   localparam int UW  = COORD_WIDTH + 1;
   localparam int PW  = 2 * UW;
   localparam int WW  = PW + 1;
   localparam int MW  = WW - 1;
   localparam int NCH = (MW + 7) / 8;
   localparam int BLW = $clog2(MW + 1);
   localparam int NB  = tfn_pkg::NORM_BITS;
   localparam int QW  = tfn_pkg::Q_W;
   localparam int RW  = tfn_pkg::ROOT_W;
   localparam int XW  = tfn_pkg::RAD_W;
   localparam int SQS = tfn_pkg::SQ_STAGES;
   localparam int DVS = tfn_pkg::DV_STAGES;

   // stage numbers
   localparam int ST_SUB = 1;
   localparam int ST_MUL = 2;
   localparam int ST_CRS = 3;
   localparam int ST_MAG = 4;
   localparam int ST_SQL = 5;
   localparam int ST_DEG = 6;
   localparam int ST_NRM = 7;
   localparam int ST_SSQ = 8;
   localparam int ST_SUM = 9;
   localparam int ST_RT0 = 10;
   localparam int ST_DIN = ST_RT0 + SQS;
   localparam int ST_DV0 = ST_DIN + 1;
   localparam int NST    = ST_DV0 + DVS - 1;

   // ---------------- configuration ----------------
   logic [31:0] min_len_ff;
   logic [63:0] min_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= tfn_pkg::MIN_LEN_RESET;
         min_sq_ff  <= 64'(tfn_pkg::MIN_LEN_RESET) * 64'(tfn_pkg::MIN_LEN_RESET);
      end else begin
         if (csr_wr_en) begin
            min_len_ff <= csr_wr_data;
         end
         min_sq_ff <= 64'(min_len_ff) * 64'(min_len_ff);
      end
   end

   // ---------------- flow control ----------------
   // a stage loads when it is empty or the next stage loads
   logic [NST:1]   vld_ff;
   logic [NST:1]   vld_in;
   logic [NST+1:1] en;
   logic           rsp_valid_ff;

   assign en[NST+1] = !rsp_valid_ff || !rsp_stall;
   for (genvar k = 1; k <= NST; k++) begin : g_en
      assign en[k] = !vld_ff[k] || en[k+1];
   end
   assign vld_in    = {vld_ff[NST-1:1], req_valid};
   assign req_stall = !en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int k = 1; k <= NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
         if (en[NST+1]) begin
            rsp_valid_ff <= vld_ff[NST];
         end
      end
   end

   // ---------------- stage 1: edges ----------------
   logic signed [COORD_WIDTH-1:0] pa [3];
   logic signed [COORD_WIDTH-1:0] pb [3];
   logic signed [COORD_WIDTH-1:0] pc [3];
   logic signed [UW-1:0]          edge_u_ff [3];
   logic signed [UW-1:0]          edge_w_ff [3];

   assign pa = '{req_a_x, req_a_y, req_a_z};
   assign pb = '{req_b_x, req_b_y, req_b_z};
   assign pc = '{req_c_x, req_c_y, req_c_z};

   always_ff @(posedge clock) begin
      if (en[ST_SUB]) begin
         for (int i = 0; i < 3; i++) begin
            edge_u_ff[i] <= UW'(pb[i]) - UW'(pa[i]);
            edge_w_ff[i] <= UW'(pc[i]) - UW'(pa[i]);
         end
      end
   end

   // ---------------- stage 2: products ----------------
   logic signed [PW-1:0] prod_ff [6];

   always_ff @(posedge clock) begin
      if (en[ST_MUL]) begin
         prod_ff[0] <= PW'(edge_u_ff[1]) * PW'(edge_w_ff[2]);
         prod_ff[1] <= PW'(edge_u_ff[2]) * PW'(edge_w_ff[1]);
         prod_ff[2] <= PW'(edge_u_ff[2]) * PW'(edge_w_ff[0]);
         prod_ff[3] <= PW'(edge_u_ff[0]) * PW'(edge_w_ff[2]);
         prod_ff[4] <= PW'(edge_u_ff[0]) * PW'(edge_w_ff[1]);
         prod_ff[5] <= PW'(edge_u_ff[1]) * PW'(edge_w_ff[0]);
      end
   end

   // ---------------- stage 3: cross product ----------------
   logic signed [WW-1:0] cross_ff [3];

   always_ff @(posedge clock) begin
      if (en[ST_CRS]) begin
         for (int i = 0; i < 3; i++) begin
            cross_ff[i] <= WW'(prod_ff[2*i]) - WW'(prod_ff[2*i+1]);
         end
      end
   end

   // ---------------- stage 4: sign and magnitude ----------------
   logic [2:0]    neg_ff [ST_MAG:NST];
   logic [MW-1:0] mag_ff [ST_MAG:ST_DEG][3];

   always_ff @(posedge clock) begin
      if (en[ST_MAG]) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[ST_MAG][i] <= cross_ff[i][WW-1];
            mag_ff[ST_MAG][i] <= MW'(cross_ff[i][WW-1] ? -cross_ff[i] : cross_ff[i]);
         end
      end
   end

   for (genvar k = ST_MAG + 1; k <= NST; k++) begin : g_neg
      always_ff @(posedge clock) begin
         if (en[k]) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end
   end

   for (genvar k = ST_MAG + 1; k <= ST_DEG; k++) begin : g_mag
      always_ff @(posedge clock) begin
         if (en[k]) begin
            mag_ff[k] <= mag_ff[k-1];
         end
      end
   end

   // ---------------- stage 5: low squares, leading-one chunks ----------------
   logic [63:0]       lo_sq_ff [3];
   logic              big_ff;
   logic [NCH-1:0]    chunk_nz_ff;
   logic [3:0]        chunk_len_ff [NCH];
   logic [NCH*8-1:0]  mag_or;
   logic [3:0]        chunk_len [NCH];

   always_comb begin
      mag_or = (NCH*8)'(mag_ff[ST_MAG][0] | mag_ff[ST_MAG][1] | mag_ff[ST_MAG][2]);
      for (int c = 0; c < NCH; c++) begin
         chunk_len[c] = 4'd0;
         for (int b = 0; b < 8; b++) begin
            if (mag_or[c*8+b]) begin
               chunk_len[c] = 4'(b + 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_SQL]) begin
         for (int i = 0; i < 3; i++) begin
            lo_sq_ff[i] <= 64'(mag_ff[ST_MAG][i][31:0]) * 64'(mag_ff[ST_MAG][i][31:0]);
         end
         big_ff <= (|mag_ff[ST_MAG][0][MW-1:32]) || (|mag_ff[ST_MAG][1][MW-1:32])
                || (|mag_ff[ST_MAG][2][MW-1:32]);
         for (int c = 0; c < NCH; c++) begin
            chunk_nz_ff[c]  <= |mag_or[c*8 +: 8];
            chunk_len_ff[c] <= chunk_len[c];
         end
      end
   end

   // ---------------- stage 6: threshold test, shift amount ----------------
   logic              deg_ff [ST_DEG:NST];
   logic [BLW-1:0]    shift_ff;
   logic [65:0]       sq_sum;
   logic [BLW-1:0]    bit_len;

   always_comb begin
      sq_sum  = 66'(lo_sq_ff[0]) + 66'(lo_sq_ff[1]) + 66'(lo_sq_ff[2]);
      bit_len = '0;
      for (int c = 0; c < NCH; c++) begin
         if (chunk_nz_ff[c]) begin
            bit_len = BLW'(c * 8) + BLW'(chunk_len_ff[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_DEG]) begin
         // exact: S <= min_length^2; any component at or above 2^32 clears it
         deg_ff[ST_DEG] <= !big_ff && (sq_sum <= 66'(min_sq_ff));
         shift_ff       <= BLW'(MW) - bit_len;
      end
   end

   for (genvar k = ST_DEG + 1; k <= NST; k++) begin : g_deg
      always_ff @(posedge clock) begin
         if (en[k]) begin
            deg_ff[k] <= deg_ff[k-1];
         end
      end
   end

   // ---------------- stage 7: normalize to 31 significant bits ----------------
   logic [NB-1:0] sc_ff [ST_NRM:ST_DIN-1][3];
   logic [MW-1:0] norm [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         norm[i] = mag_ff[ST_DEG][i] << shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_NRM]) begin
         for (int i = 0; i < 3; i++) begin
            sc_ff[ST_NRM][i] <= norm[i][MW-1 -: NB];
         end
      end
   end

   for (genvar k = ST_NRM + 1; k <= ST_DIN - 1; k++) begin : g_sc
      always_ff @(posedge clock) begin
         if (en[k]) begin
            sc_ff[k] <= sc_ff[k-1];
         end
      end
   end

   // ---------------- stages 8, 9: sum of scaled squares ----------------
   logic [2*NB-1:0] sc_sq_ff [3];
   logic [XW-1:0]   ss_ff;

   always_ff @(posedge clock) begin
      if (en[ST_SSQ]) begin
         for (int i = 0; i < 3; i++) begin
            sc_sq_ff[i] <= (2*NB)'(sc_ff[ST_NRM][i]) * (2*NB)'(sc_ff[ST_NRM][i]);
         end
      end
      if (en[ST_SUM]) begin
         ss_ff <= XW'(sc_sq_ff[0]) + XW'(sc_sq_ff[1]) + XW'(sc_sq_ff[2]);
      end
   end

   // ---------------- stages 10..13: square root ----------------
   tfn_pkg::root_type root_ff [SQS];

   for (genvar j = 0; j < SQS; j++) begin : g_root
      tfn_pkg::root_type src;
      tfn_pkg::root_type nx;
      if (j == 0) begin : g_first
         assign src = '{x: ss_ff, q: '0, r: '0};
      end else begin : g_next
         assign src = root_ff[j-1];
      end
      always_comb begin
         nx = src;
         for (int s = 0; s < tfn_pkg::RT_STEPS; s++) begin
            nx = tfn_pkg::root_step(nx);
         end
      end
      always_ff @(posedge clock) begin
         if (en[ST_RT0 + j]) begin
            root_ff[j] <= nx;
         end
      end
   end

   // ---------------- stage 14: divide setup ----------------
   logic [RW-1:0]    len_ff [ST_DIN:NST-1];
   tfn_pkg::div_type din_ff [3];
   logic [RW-1:0]    root_len;
   logic [2*QW-1:0]  numer [3];

   assign root_len = root_ff[SQS-1].q;

   always_comb begin
      // round half away: (sc * 2^30 + len/2) / len
      for (int i = 0; i < 3; i++) begin
         numer[i] = (2*QW)'({sc_ff[ST_DIN-1][i], tfn_pkg::ONE_SHIFT'(0)})
                  + (2*QW)'(root_len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_DIN]) begin
         len_ff[ST_DIN] <= root_len;
         for (int i = 0; i < 3; i++) begin
            din_ff[i].r <= RW'(numer[i][2*QW-1:QW]);
            din_ff[i].n <= numer[i][QW-1:0];
            din_ff[i].q <= '0;
         end
      end
   end

   for (genvar k = ST_DIN + 1; k <= NST - 1; k++) begin : g_len
      always_ff @(posedge clock) begin
         if (en[k]) begin
            len_ff[k] <= len_ff[k-1];
         end
      end
   end

   // ---------------- stages 15..18: three dividers ----------------
   tfn_pkg::div_type div_ff [DVS][3];

   for (genvar j = 0; j < DVS; j++) begin : g_div
      tfn_pkg::div_type src [3];
      tfn_pkg::div_type nx  [3];
      if (j == 0) begin : g_first
         assign src = din_ff;
      end else begin : g_next
         assign src = div_ff[j-1];
      end
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            nx[i] = src[i];
            for (int s = 0; s < tfn_pkg::DV_STEPS; s++) begin
               if (j * tfn_pkg::DV_STEPS + s < QW) begin
                  nx[i] = tfn_pkg::div_step(nx[i], len_ff[ST_DV0 + j - 1]);
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en[ST_DV0 + j]) begin
            div_ff[j] <= nx;
         end
      end
   end

   // ---------------- output register ----------------
   logic signed [31:0] normal_ff [3];
   logic               rsp_deg_ff;

   always_ff @(posedge clock) begin
      if (en[NST+1]) begin
         rsp_deg_ff <= deg_ff[NST];
         for (int i = 0; i < 3; i++) begin
            if (deg_ff[NST]) begin
               normal_ff[i] <= '0;
            end else if (neg_ff[NST][i]) begin
               normal_ff[i] <= -$signed(32'(div_ff[DVS-1][i].q));
            end else begin
               normal_ff[i] <= $signed(32'(div_ff[DVS-1][i].q));
            end
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_normal_x   = normal_ff[0];
   assign rsp_normal_y   = normal_ff[1];
   assign rsp_normal_z   = normal_ff[2];
   assign rsp_degenerate = rsp_deg_ff;

   // ---------------- checks ----------------
   `TFN_ASSERT_IMPL(a_deg_zero, clock, reset, rsp_valid && rsp_degenerate,
      rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
   `TFN_ASSERT_IMPL(a_unit_range, clock, reset, rsp_valid && !rsp_degenerate,
      rsp_normal_x <= 32'sd1073741824 && rsp_normal_x >= -32'sd1073741824 &&
      rsp_normal_y <= 32'sd1073741824 && rsp_normal_y >= -32'sd1073741824 &&
      rsp_normal_z <= 32'sd1073741824 && rsp_normal_z >= -32'sd1073741824)
   `TFN_ASSERT_IMPL(a_len_norm, clock, reset, vld_ff[ST_DIN] && !deg_ff[ST_DIN],
      len_ff[ST_DIN] >= (RW'(1) << tfn_pkg::ONE_SHIFT))
   `TFN_ASSERT_NEXT(a_move, clock, reset, vld_ff[ST_SUM] && en[ST_RT0], vld_ff[ST_RT0])

endmodule
